[rtl/assert_macros.svh]
// Assertion macros for the inverse participation ratio block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IPR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define IPR_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");
`else
`define IPR_ASSERT(label, prop)
`define IPR_ASSERT_NEXT(label, cause, effect)
`endif
`endif

[rtl/ipr_pkg.sv]
// Shared constants, types and state codes of the inverse participation ratio block.
// No dependencies.
package ipr_pkg;

    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_MAX_BINS    = 256;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int BIN_COUNT_W = 9;
    localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 9'd10;

    localparam int RATIO_W   = 25;
    localparam int TOTAL_W   = 13;
    localparam int FRAC_BITS = 16;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 25'd65536;
    localparam longint unsigned RATIO_MAX = 64'd33554431;

    localparam int QUEUE_DEPTH = 2;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_BIN_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_OFFSET,
        ST_MUL,
        ST_BIN_START,
        ST_BIN_WAIT,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_SUM,
        ST_DRAIN,
        ST_RATIO_START,
        ST_RATIO_WAIT,
        ST_OUT
    } t_back_state;

    typedef struct packed {
        logic clearing;
        logic store_busy;
    } t_back_stat;

endpackage

[rtl/ipr_if.sv]
// Stream interfaces for sample words in and result words out.
// Depends on ipr_pkg.
interface ipr_in_if import ipr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface ipr_out_if import ipr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] ratio;
    logic [TOTAL_W-1:0] sample_total;
    logic               overflowed;

    modport source (output valid, output ratio, output sample_total, output overflowed,
                    input ready);
    modport sink (input valid, input ratio, input sample_total, input overflowed,
                  output ready);
endinterface

[rtl/histogram_inverse_participation_ratio_unit.sv]
// Top level of the histogram inverse participation ratio block: register port and wiring.
// Depends on ipr_pkg, ipr_if, ipr_front, ipr_fifo, ipr_back and assert_macros.svh.
//
// Samples load at one word per cycle, whenever input is not held off, into a store of
// MAX_SAMPLES entries while min, max and count are tracked; the word marked last closes the
// set and queues it for the back end. The back end then sorts each stored sample into a bin
// with the one-bit-per-cycle divider and a read-modify-write of the bin counter memory, then
// sums the squared counts of the active bins and divides out the ratio. Input is held off
// while the back end reads the sample store or a set waits in the queue; once binning ends,
// the next set loads while the sum, the ratio and an untaken result are still pending. After
// reset, a clearing pass zeroes the MAX_BINS bin counters before the first word is taken.
`include "assert_macros.svh"

module histogram_inverse_participation_ratio_unit import ipr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MAX_BINS    = DEF_MAX_BINS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ipr_in_if.sink            i_in,
    ipr_out_if.source         o_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready
);
    localparam int SB  = SAMPLE_BITS;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NBW = $clog2(MAX_BINS + 1);
    localparam int JW  = 2 * SB + CW + 1 + NBW;

    logic [BIN_COUNT_W-1:0] r_bin_count;
    logic [REG_IDX_W-1:0]   w_reg_idx;
    logic                   w_cfg_wr;

    t_back_stat           w_stat;
    logic                 w_push, w_pop, w_fifo_empty, w_fifo_full;
    logic [JW-1:0]        w_job, w_fifo_job;
    logic                 w_st_en;
    logic [SAW-1:0]       w_st_addr;
    logic signed [SB-1:0] w_st_data;

    assign o_pready  = 1'b1;
    assign w_reg_idx = i_paddr[APB_AW-1:2];
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata  = (w_reg_idx == REG_BIN_COUNT) ? APB_DW'(r_bin_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= BIN_COUNT_RST;
        end else if (w_cfg_wr && (w_reg_idx == REG_BIN_COUNT)) begin
            r_bin_count <= i_pwdata[BIN_COUNT_W-1:0];
        end
    end

    ipr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_BINS    (MAX_BINS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_bin_count  (r_bin_count),
        .i_stat       (w_stat),
        .i_fifo_empty (w_fifo_empty),
        .o_push       (w_push),
        .o_job        (w_job),
        .o_st_en      (w_st_en),
        .o_st_addr    (w_st_addr),
        .o_st_data    (w_st_data)
    );

    ipr_fifo #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job),
        .i_pop   (w_pop),
        .o_data  (w_fifo_job),
        .o_empty (w_fifo_empty),
        .o_full  (w_fifo_full)
    );

    ipr_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_BINS    (MAX_BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_st_en     (w_st_en),
        .i_st_addr   (w_st_addr),
        .i_st_data   (w_st_data),
        .i_job_valid (!w_fifo_empty),
        .i_job       (w_fifo_job),
        .o_pop       (w_pop),
        .o_stat      (w_stat),
        .o_out       (o_out)
    );

    `IPR_ASSERT(a_accept_store_free, (i_in.valid && i_in.ready) |-> (!w_stat.store_busy && !w_stat.clearing))
    `IPR_ASSERT(a_push_not_full, w_push |-> (w_fifo_empty && !w_fifo_full))
    `IPR_ASSERT_NEXT(a_pop_starts_binning, w_pop, w_stat.store_busy)
    `IPR_ASSERT(a_ratio_at_least_one, o_out.valid |-> (o_out.ratio >= RATIO_ONE))
endmodule

[rtl/ipr_fifo.sv]
// Short job queue between the sample front end and the binning back end.
// Depends on ipr_pkg.
module ipr_fifo import ipr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

[rtl/ipr_front.sv]
// Front end: takes sample words, tracks min, max and count, writes the sample store,
// and queues one job per set. Depends on ipr_pkg and ipr_if.
module ipr_front import ipr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MAX_BINS    = DEF_MAX_BINS,
    localparam int SB  = SAMPLE_BITS,
    localparam int CW  = $clog2(MAX_SAMPLES + 1),
    localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int NBW = $clog2(MAX_BINS + 1),
    localparam int JW  = 2 * SB + CW + 1 + NBW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ipr_in_if.sink                 i_in,
    input  logic [BIN_COUNT_W-1:0] i_bin_count,
    input  t_back_stat             i_stat,
    input  logic                   i_fifo_empty,
    output logic                   o_push,
    output logic [JW-1:0]          o_job,
    output logic                   o_st_en,
    output logic [SAW-1:0]         o_st_addr,
    output logic signed [SB-1:0]   o_st_data
);
    localparam logic signed [SB-1:0] MAX_POS = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] MIN_NEG = {1'b1, {(SB - 1){1'b0}}};

    logic signed [SB-1:0] r_min, r_max, n_min, n_max;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_drop, n_drop;
    logic                 w_accept, w_full, w_take;
    logic [NBW-1:0]       w_nb;

    assign i_in.ready = !i_stat.clearing && !i_stat.store_busy && i_fifo_empty;

    always_comb begin
        w_accept = i_in.valid && i_in.ready;
        w_full   = (r_cnt == CW'(MAX_SAMPLES));
        w_take   = w_accept && !w_full;
        n_min    = (w_take && (i_in.sample < r_min)) ? i_in.sample : r_min;
        n_max    = (w_take && (i_in.sample > r_max)) ? i_in.sample : r_max;
        n_cnt    = w_take ? r_cnt + CW'(1) : r_cnt;
        n_drop   = r_drop || (w_accept && w_full);
        if (i_bin_count == '0) begin
            w_nb = NBW'(1);
        end else if (32'(i_bin_count) > 32'(MAX_BINS)) begin
            w_nb = NBW'(MAX_BINS);
        end else begin
            w_nb = NBW'(i_bin_count);
        end
    end

    assign o_push    = w_accept && i_in.last_sample;
    assign o_job     = {n_min, n_max, n_cnt, n_drop, w_nb};
    assign o_st_en   = w_take;
    assign o_st_addr = r_cnt[SAW-1:0];
    assign o_st_data = i_in.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_min  <= MAX_POS;
            r_max  <= MIN_NEG;
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else begin
            r_min  <= n_min;
            r_max  <= n_max;
            r_cnt  <= n_cnt;
            r_drop <= n_drop;
        end
    end
endmodule

[rtl/ipr_div.sv]
// Restoring divider, one quotient bit per cycle, shared by bin sorting and the final ratio.
// Depends on nothing outside this file.
module ipr_div #(
    parameter int RW = 33,
    parameter int LW = 42,
    localparam int SW = $clog2(LW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [RW-1:0] i_rem,
    input  logic [LW-1:0] i_bits,
    input  logic [SW-1:0] i_steps,
    input  logic [RW-1:0] i_divisor,
    output logic          o_busy,
    output logic [LW-1:0] o_quot
);
    logic [SW-1:0] r_cnt;
    logic [RW-1:0] r_rem, r_div;
    logic [LW-1:0] r_bits, r_quot;
    logic [RW:0]   w_trial, w_diff;
    logic          w_ge;

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

    always_comb begin
        w_trial = {r_rem, r_bits[LW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (o_busy) begin
            r_cnt <= r_cnt - SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_bits <= i_bits;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (o_busy) begin
            r_rem  <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_bits <= r_bits << 1;
            r_quot <= {r_quot[LW-2:0], w_ge};
        end
    end
endmodule

[rtl/ipr_back.sv]
// Back end: sample store, bin counters, binning pass, sum of squares, ratio and result register.
// Depends on ipr_pkg, ipr_if and ipr_div.
module ipr_back import ipr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MAX_BINS    = DEF_MAX_BINS,
    localparam int SB  = SAMPLE_BITS,
    localparam int CW  = $clog2(MAX_SAMPLES + 1),
    localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int NBW = $clog2(MAX_BINS + 1),
    localparam int JW  = 2 * SB + CW + 1 + NBW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_st_en,
    input  logic [SAW-1:0]       i_st_addr,
    input  logic signed [SB-1:0] i_st_data,
    input  logic                 i_job_valid,
    input  logic [JW-1:0]        i_job,
    output logic                 o_pop,
    output t_back_stat           o_stat,
    ipr_out_if.source            o_out
);
    localparam int QB  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SQW = 2 * CW;
    localparam int DVW = SQW + FRAC_BITS;
    localparam int RW  = (SB + 1 > SQW) ? SB + 1 : SQW;
    localparam int LW  = (DVW > QB) ? DVW : QB;
    localparam int SW  = $clog2(LW + 1);
    localparam logic [QB-1:0] LAST_BIN = QB'(MAX_BINS - 1);

    t_back_state r_state, n_state;

    logic signed [SB-1:0] r_min, r_max, r_srd;
    logic [CW-1:0]        r_n, r_idx, r_brd;
    logic                 r_drop;
    logic [NBW-1:0]       r_nb;
    logic [SB-1:0]        r_off;
    logic [SB:0]          r_span;
    logic [SB+NBW-1:0]    r_prod;
    logic [QB-1:0]        r_bin, r_sidx, r_cidx;
    logic                 r_p1, r_p2;
    logic [SQW-1:0]       r_sq, r_acc, r_nsq;

    logic                 r_ovalid, r_ovf;
    logic [RATIO_W-1:0]   r_ratio;
    logic [TOTAL_W-1:0]   r_total;

    logic signed [SB-1:0] w_jmin, w_jmax;
    logic [CW-1:0]        w_jn;
    logic                 w_jdrop;
    logic [NBW-1:0]       w_jnb;

    logic                 w_dstart, w_dbusy;
    logic [RW-1:0]        w_drem, w_ddiv;
    logic [LW-1:0]        w_dbits, w_dquot;
    logic [SW-1:0]        w_dsteps;
    logic [QB-1:0]        w_q;

    logic                 w_bwe, w_oload, w_sat;
    logic [QB-1:0]        w_bwa, w_bra;
    logic [CW-1:0]        w_bwd;

    logic signed [SB-1:0] r_store [MAX_SAMPLES];
    logic [CW-1:0]        r_bins [MAX_BINS];

    assign {w_jmin, w_jmax, w_jn, w_jdrop, w_jnb} = i_job;
    assign w_q   = w_dquot[QB-1:0];
    assign w_sat = {{(64 - LW){1'b0}}, w_dquot} > 64'(RATIO_MAX);

    ipr_div #(
        .RW (RW),
        .LW (LW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_dstart),
        .i_rem     (w_drem),
        .i_bits    (w_dbits),
        .i_steps   (w_dsteps),
        .i_divisor (w_ddiv),
        .o_busy    (w_dbusy),
        .o_quot    (w_dquot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_dstart = 1'b0;
        w_drem   = '0;
        w_dbits  = '0;
        w_ddiv   = '0;
        w_dsteps = '0;
        w_bwe    = 1'b0;
        w_bwa    = r_bin;
        w_bwd    = r_brd + CW'(1);
        w_bra    = r_bin;
        w_oload  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_bwe = 1'b1;
                w_bwa = r_cidx;
                w_bwd = '0;
                if (r_cidx == LAST_BIN) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:   n_state = ST_OFFSET;
            ST_OFFSET: n_state = ST_MUL;
            ST_MUL:    n_state = ST_BIN_START;
            ST_BIN_START: begin
                w_dstart = 1'b1;
                w_drem   = RW'(r_prod >> QB);
                w_dbits  = LW'(r_prod[QB-1:0]) << (LW - QB);
                w_ddiv   = RW'(r_span);
                w_dsteps = SW'(QB);
                n_state  = ST_BIN_WAIT;
            end
            ST_BIN_WAIT: begin
                if (!w_dbusy) begin
                    n_state = ST_BIN_RD;
                end
            end
            ST_BIN_RD: n_state = ST_BIN_WR;
            ST_BIN_WR: begin
                w_bwe   = 1'b1;
                n_state = (r_idx + CW'(1) == r_n) ? ST_SUM : ST_LOAD;
            end
            ST_SUM: begin
                w_bra = r_sidx;
                w_bwe = 1'b1;
                w_bwa = r_sidx;
                w_bwd = '0;
                if (r_sidx == QB'(r_nb - NBW'(1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_state = ST_RATIO_START;
                end
            end
            ST_RATIO_START: begin
                w_dstart = 1'b1;
                w_drem   = '0;
                w_dbits  = LW'({r_nsq, {FRAC_BITS{1'b0}}}) << (LW - DVW);
                w_ddiv   = RW'(r_acc);
                w_dsteps = SW'(DVW);
                n_state  = ST_RATIO_WAIT;
            end
            ST_RATIO_WAIT: begin
                if (!w_dbusy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    w_oload = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cidx   <= '0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_cidx <= r_cidx + QB'(1);
            end
            r_p1 <= (r_state == ST_SUM);
            r_p2 <= r_p1;
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= r_brd * r_brd;
        if (r_p2) begin
            r_acc <= r_acc + r_sq;
        end
        case (r_state)
            ST_IDLE: begin
                r_min  <= w_jmin;
                r_max  <= w_jmax;
                r_n    <= w_jn;
                r_drop <= w_jdrop;
                r_nb   <= w_jnb;
                r_idx  <= '0;
                r_sidx <= '0;
                r_acc  <= '0;
            end
            ST_LOAD:   r_span <= {1'b0, SB'(r_max - r_min)} + (SB + 1)'(1);
            ST_OFFSET: r_off  <= SB'(r_srd - r_min);
            ST_MUL:    r_prod <= r_off * r_nb;
            ST_BIN_WAIT: begin
                if (!w_dbusy) begin
                    r_bin <= (32'(w_q) >= 32'(r_nb)) ? QB'(r_nb - NBW'(1)) : w_q;
                end
            end
            ST_BIN_WR: r_idx  <= r_idx + CW'(1);
            ST_SUM:    r_sidx <= r_sidx + QB'(1);
            ST_DRAIN:  r_nsq  <= r_n * r_n;
            ST_OUT: begin
                if (w_oload) begin
                    r_ratio <= w_sat ? {RATIO_W{1'b1}} : RATIO_W'(w_dquot);
                    r_total <= TOTAL_W'(r_n);
                    r_ovf   <= r_drop;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_st_en) begin
            r_store[i_st_addr] <= i_st_data;
        end
        r_srd <= r_store[r_idx[SAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_bwe) begin
            r_bins[w_bwa] <= w_bwd;
        end
        r_brd <= r_bins[w_bra];
    end

    assign o_stat.clearing   = (r_state == ST_CLEAR);
    assign o_stat.store_busy = (r_state == ST_LOAD) || (r_state == ST_OFFSET) ||
                               (r_state == ST_MUL) || (r_state == ST_BIN_START) ||
                               (r_state == ST_BIN_WAIT) || (r_state == ST_BIN_RD) ||
                               (r_state == ST_BIN_WR);

    assign o_out.valid        = r_ovalid;
    assign o_out.ratio        = r_ratio;
    assign o_out.sample_total = r_total;
    assign o_out.overflowed   = r_ovf;
endmodule

[test/histogram_inverse_participation_ratio_unit_test.sv]
// Testbench for histogram_inverse_participation_ratio_unit: sample sets in, ratio words out.
// Depends on ipr_pkg, ipr_if and the block; a histogram predictor or typed rows check words.
`timescale 1ns / 100ps

module histogram_inverse_participation_ratio_unit_test;
    import ipr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 800;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [TOTAL_W-1:0] total;
        logic               ovf;
    } ratio_word_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_STEPS,
        SPREAD_EXTREMES,
        SPREAD_WIDE
    } spread_t;

    typedef struct {
        bit                 set_cfg;
        logic [31:0]        cfg_word;
        logic signed [31:0] sample;
        bit                 last;
        bit                 typed;
        logic [RATIO_W-1:0] ratio;
        logic [TOTAL_W-1:0] total;
        bit                 ovf;
    } directed_row_t;

    directed_row_t directed [0:DIRECTED_ROWS-1] = '{
        '{0, 32'd0, 32'sd0, 1, 1, 25'd65536, 13'd1, 0},
        '{0, 32'd0, 32'h8000_0000, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'h7FFF_FFFF, 1, 1, 25'd131072, 13'd2, 0},
        '{0, 32'd0, 32'sd5, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd5, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd5, 1, 1, 25'd65536, 13'd3, 0},
        '{1, 32'd0, -32'sd1, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd1000, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, -32'sd70000, 1, 1, 25'd65536, 13'd3, 0},
        '{1, 32'd256, 32'sd0, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd65536, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd131072, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd196608, 1, 1, 25'd262144, 13'd4, 0},
        '{1, 32'hFFFF_FE05, 32'sd7, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd7, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, -32'sd7, 1, 0, 25'd0, 13'd0, 0},
        '{1, 32'd511, 32'h7FFF_FFFF, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'h8000_0000, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd0, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'sd1, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, -32'sd1, 1, 0, 25'd0, 13'd0, 0},
        '{1, 32'd257, 32'h5555_5555, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'hAAAA_AAAA, 0, 0, 25'd0, 13'd0, 0},
        '{0, 32'd0, 32'h0001_0000, 1, 0, 25'd0, 13'd0, 0},
        '{1, 32'd10, 32'h1234_5678, 1, 1, 25'd65536, 13'd1, 0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_psel;
    logic              i_penable;
    logic              i_pwrite;
    logic [APB_AW-1:0] i_paddr;
    logic [APB_DW-1:0] i_pwdata;
    logic [APB_DW-1:0] o_prdata;
    logic              o_pready;

    ipr_in_if  in_if ();
    ipr_out_if out_if ();

    histogram_inverse_participation_ratio_unit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    ratio_word_t              pending_ratios [$];
    bit                       failed;
    int unsigned              cycle_count;

    logic [BIN_COUNT_W-1:0]   bin_count_reg = BIN_COUNT_RST;
    longint                   set_store [0:DEF_MAX_SAMPLES-1];
    int unsigned              set_size = 0;
    longint                   set_min = 64'sd2147483647;
    longint                   set_max = -64'sd2147483648;
    bit                       set_dropped = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("histogram_inverse_participation_ratio_unit test failed");
            $finish;
        end
    end

    function automatic bit fold_into_histogram(input logic signed [31:0] s, input bit last,
                                               output ratio_word_t res);
        int unsigned     nb;
        int unsigned     slot;
        int unsigned     counts [0:DEF_MAX_BINS-1];
        longint          off;
        longint          span;
        longint unsigned sq;
        longint unsigned n;
        longint unsigned q;
        res = '0;
        if (set_size < DEF_MAX_SAMPLES) begin
            set_store[set_size] = longint'(s);
            set_size++;
            if (longint'(s) < set_min) set_min = longint'(s);
            if (longint'(s) > set_max) set_max = longint'(s);
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) return 1'b0;

        if (bin_count_reg == 0) nb = 1;
        else if (bin_count_reg > DEF_MAX_BINS) nb = DEF_MAX_BINS;
        else nb = bin_count_reg;
        for (int i = 0; i < DEF_MAX_BINS; i++) counts[i] = 0;
        span = set_max - set_min + 1;
        for (int unsigned i = 0; i < set_size; i++) begin
            off = set_store[i] - set_min;
            slot = int'((off * longint'(nb)) / span);
            if (slot >= nb) slot = nb - 1;
            counts[slot]++;
        end
        sq = 0;
        for (int unsigned i = 0; i < nb; i++) sq += longint'(counts[i]) * longint'(counts[i]);
        n = set_size;
        q = (sq == 0) ? 0 : ((n * n) << FRAC_BITS) / sq;
        if (q > RATIO_MAX) q = RATIO_MAX;
        res.ratio = q[RATIO_W-1:0];
        res.total = n[TOTAL_W-1:0];
        res.ovf   = set_dropped;

        set_min = 64'sd2147483647;
        set_max = -64'sd2147483648;
        set_size = 0;
        set_dropped = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] shape_sample(input spread_t mode,
                                                        input logic signed [31:0] base);
        case (mode)
            SPREAD_FULL:   return $urandom;
            SPREAD_NARROW: return base + $urandom_range(0, 15);
            SPREAD_STEPS:  return base + ($urandom_range(0, 3) << 16);
            SPREAD_EXTREMES: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return $urandom;
                endcase
            end
            default:       return base + $urandom_range(0, 1 << 20);
        endcase
    endfunction

    function automatic logic [BIN_COUNT_W-1:0] pick_bin_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return BIN_COUNT_W'($urandom_range(257, 511));
            default: return BIN_COUNT_W'($urandom_range(2, 255));
        endcase
    endfunction

    task automatic send_word(input logic signed [31:0] s, input bit last, input bit burst,
                             output bit produced, output ratio_word_t predicted);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample      <= s;
        in_if.last_sample <= last;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        produced = fold_into_histogram(s, last, predicted);
    endtask

    task automatic send_set(input int unsigned len, input spread_t mode, input bit burst);
        logic signed [31:0] base;
        ratio_word_t        predicted;
        bit                 produced;
        base = $urandom;
        for (int unsigned k = 0; k < len; k++) begin
            send_word(shape_sample(mode, base), k == len - 1, burst, produced, predicted);
            if (produced) pending_ratios.push_back(predicted);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_ratios.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bin_count(input logic [31:0] word);
        drain_results();
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {REG_BIN_COUNT, 2'b00};
        i_pwdata  <= word;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (o_pready !== 1'b1) @(posedge i_clk);
        bin_count_reg = word[BIN_COUNT_W-1:0];
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    initial begin
        int unsigned fast_left;
        int unsigned gap;
        bit          fast;
        ratio_word_t want;
        fast_left = 0;
        fast = 1'b0;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (fast_left == 0) begin
                fast = ($urandom_range(0, 3) == 0);
                fast_left = $urandom_range(4, 20);
            end
            fast_left--;
            gap = fast ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (out_if.valid !== 1'b1) @(posedge i_clk);
            if (pending_ratios.size() == 0) begin
                $error("result word with none expected: ratio %0d total %0d",
                       out_if.ratio, out_if.sample_total);
                failed = 1'b1;
            end else begin
                want = pending_ratios.pop_front();
                if (out_if.ratio !== want.ratio) begin
                    $error("ratio: expected %0d, got %0d", want.ratio, out_if.ratio);
                    failed = 1'b1;
                end
                if (out_if.sample_total !== want.total) begin
                    $error("sample_total: expected %0d, got %0d", want.total,
                           out_if.sample_total);
                    failed = 1'b1;
                end
                if (out_if.overflowed !== want.ovf) begin
                    $error("overflowed: expected %0d, got %0d", want.ovf, out_if.overflowed);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int unsigned   left;
        int unsigned   set_len;
        int unsigned   pick;
        bit            produced;
        ratio_word_t   predicted;
        ratio_word_t   typed_word;
        failed      = 1'b0;
        cycle_count = 0;
        i_rst_n           <= 1'b0;
        i_psel            <= 1'b0;
        i_penable         <= 1'b0;
        i_pwrite          <= 1'b0;
        i_paddr           <= '0;
        i_pwdata          <= '0;
        in_if.valid       <= 1'b0;
        in_if.sample      <= '0;
        in_if.last_sample <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].set_cfg) write_bin_count(directed[r].cfg_word);
            send_word(directed[r].sample, directed[r].last, $urandom_range(0, 1) == 1,
                      produced, predicted);
            if (produced) begin
                typed_word.ratio = directed[r].ratio;
                typed_word.total = directed[r].total;
                typed_word.ovf   = directed[r].ovf;
                pending_ratios.push_back(directed[r].typed ? typed_word : predicted);
            end
        end

        send_set(3, SPREAD_STEPS, 1'b0);

        left = RANDOM_ITEMS;
        while (left > 0) begin
            if ($urandom_range(0, 5) == 0)
                write_bin_count({23'($urandom_range(0, (1 << 23) - 1)), pick_bin_count()});
            pick = $urandom_range(0, 9);
            if (pick < 7) set_len = $urandom_range(1, 12);
            else if (pick < 9) set_len = $urandom_range(13, 64);
            else set_len = $urandom_range(65, 200);
            if (set_len > left) set_len = left;
            send_set(set_len, spread_t'($urandom_range(0, 4)), $urandom_range(0, 3) == 0);
            left -= set_len;
        end

        drain_results();
        if (!failed)
            $display("histogram_inverse_participation_ratio_unit test passed");
        else
            $display("histogram_inverse_participation_ratio_unit test failed");
        $finish;
    end

endmodule

[histogram_inverse_participation_ratio_unit.f]
+incdir+rtl
rtl/ipr_pkg.sv
rtl/ipr_if.sv
rtl/ipr_fifo.sv
rtl/ipr_front.sv
rtl/ipr_div.sv
rtl/ipr_back.sv
rtl/histogram_inverse_participation_ratio_unit.sv
test/histogram_inverse_participation_ratio_unit_test.sv
